FILE: src/dfs_spanning_forest_parents_top_assert.svh
// Assertion macros for the depth-first forest block.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef DFS_SPANNING_FOREST_PARENTS_TOP_ASSERT_SVH
`define DFS_SPANNING_FOREST_PARENTS_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dfs assertion failed");

// Next-cycle implication, disabled during reset.
`define DFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dfs assertion failed");

`endif

FILE: src/dfs_pkg.sv
// Shared types and constants for the depth-first forest block.
// No dependencies; used by every module of the block except dfs_ram.
`default_nettype none

package dfs_pkg;

  localparam int MAX_VERTS   = 32;
  localparam int VERT_W      = 5;
  localparam int STACK_DEPTH = 1024;
  localparam int SA_W        = $clog2(STACK_DEPTH);
  localparam int SP_W        = SA_W + 1;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_RUN   = 2'd2;

  typedef logic [VERT_W-1:0] vert_t;

  typedef struct packed {
    logic [1:0] action;
    vert_t      first_vertex;
    vert_t      second_vertex;
  } in_req_t;

  typedef struct packed {
    vert_t vertex;
    vert_t parent_vertex;
    logic  last;
  } out_res_t;

  typedef struct packed {
    logic clear_graph;
    logic set_edge;
    logic start_run;
    logic root_push;
    logic root_next;
    logic pop;
    logic mark;
    logic scan_step;
    logic emit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic root_visited;
    logic root_last;
    logic sp_zero;
    logic popped_visited;
    logic scan_last;
    logic scan_push;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: src/dfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/dfs_datapath.sv
// Datapath: adjacency matrix, visited bits, parent table, walk stack, result register.
// Depends on dfs_pkg and dfs_ram.
`default_nettype none

module dfs_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dfs_pkg::in_req_t   in_req,
  input  wire logic               cfg_wr_en,
  input  wire dfs_pkg::vert_t     cfg_wr_data,
  input  wire dfs_pkg::dp_cmd_t   cmd,
  output dfs_pkg::dp_status_t     status,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output dfs_pkg::out_res_t       out_res
);

  import dfs_pkg::*;

  vert_t                 vertex_count;
  logic [MAX_VERTS-1:0]  adj [MAX_VERTS];
  logic [MAX_VERTS-1:0]  visited;
  vert_t                 parent [MAX_VERTS];
  logic [SP_W-1:0]       sp;
  vert_t                 root;
  vert_t                 scan_idx;
  vert_t                 emit_idx;
  vert_t                 u_vert;
  logic [MAX_VERTS-1:0]  u_row;

  logic                  push_en;
  vert_t                 push_vert;
  vert_t                 push_from;
  logic [SP_W-1:0]       sp_dec;
  vert_t                 popped;
  logic                  ram_we;

  assign sp_dec    = sp - 1'b1;
  assign push_en   = cmd.root_push | (cmd.scan_step & status.scan_push);
  assign push_vert = cmd.root_push ? root : scan_idx;
  assign push_from = cmd.root_push ? '0 : u_vert;
  // a full stack drops the push; the parent entry is still written
  assign ram_we    = push_en && (sp < SP_W'(STACK_DEPTH));

  dfs_ram #(
    .WIDTH(VERT_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp[SA_W-1:0]),
    .wdata (push_vert),
    .raddr (sp_dec[SA_W-1:0]),
    .rdata (popped)
  );

  always_comb begin
    status.n_zero         = (vertex_count == '0);
    status.root_visited   = visited[root];
    status.root_last      = (root == vertex_count);
    status.sp_zero        = (sp == '0);
    status.popped_visited = visited[popped];
    status.scan_last      = (scan_idx == vertex_count);
    status.scan_push      = u_row[scan_idx] & ~visited[scan_idx];
    status.emit_last      = (emit_idx == vertex_count);
    status.out_free       = ~out_valid | out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= vert_t'(1);
    end else if (cfg_wr_en) begin
      vertex_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_graph) begin
      for (int i = 0; i < MAX_VERTS; i++) begin
        adj[i] <= '0;
      end
    end else if (cmd.set_edge) begin
      adj[in_req.first_vertex][in_req.second_vertex] <= 1'b1;
      adj[in_req.second_vertex][in_req.first_vertex] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start_run) begin
      visited <= '0;
    end else if (cmd.mark) begin
      visited[popped] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.pop) begin
      sp <= sp_dec;
    end else if (ram_we) begin
      sp <= sp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      parent[push_vert] <= push_from;
    end
    if (cmd.start_run) begin
      root     <= vert_t'(1);
      emit_idx <= vert_t'(1);
    end
    if (cmd.root_next) begin
      root <= root + 1'b1;
    end
    if (cmd.mark) begin
      u_vert   <= popped;
      u_row    <= adj[popped];
      scan_idx <= vert_t'(1);
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
    end
    if (cmd.emit_load) begin
      out_res.vertex        <= emit_idx;
      out_res.parent_vertex <= parent[emit_idx];
      out_res.last          <= (emit_idx == vertex_count);
      emit_idx              <= emit_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: src/dfs_ctrl.sv
// Controller state machine: sequences edge loads, the stack walk and result emission.
// Depends on dfs_pkg.
`default_nettype none

module dfs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_action,
  input  wire dfs_pkg::dp_status_t status,
  output dfs_pkg::dp_cmd_t         cmd
);

  import dfs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ROOT  = 6'b000010,
    S_POP   = 6'b000100,
    S_CHECK = 6'b001000,
    S_SCAN  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_action)
            ACT_CLEAR: cmd.clear_graph = 1'b1;
            ACT_ADD:   cmd.set_edge = 1'b1;
            ACT_RUN: begin
              if (!status.n_zero) begin
                cmd.start_run = 1'b1;
                state_next    = S_ROOT;
              end
            end
            default: ;
          endcase
        end
      end
      S_ROOT: begin
        if (status.root_visited) begin
          if (status.root_last) begin
            state_next = S_EMIT;
          end else begin
            cmd.root_next = 1'b1;
          end
        end else begin
          cmd.root_push = 1'b1;
          state_next    = S_POP;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.popped_visited) begin
          state_next = status.sp_zero ? S_ROOT : S_POP;
        end else begin
          cmd.mark   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = (status.sp_zero && !status.scan_push) ? S_ROOT : S_POP;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/dfs_spanning_forest_parents_top.sv
// Top level of the depth-first spanning forest block: controller plus datapath.
// Depends on dfs_pkg, dfs_ctrl, dfs_datapath and the assertion macro header.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | in_req  (action, first_vertex, second_vertex)
//   out     | output    | out_valid / out_ready| out_res (vertex, parent_vertex, last)
//   cfg     | input     | cfg_wr_en            | cfg_wr_data (vertex_count)
//
// Clear and add requests may arrive back to back.
// Run with n vertices: a root check per root plus a root push per tree, a pop and a
// check per stack pop, a scan of all n vertices per vertex marked, then one result
// per cycle while the out channel is free; run time is set by the single-port walk
// stack and the one-neighbor-per-cycle scan.
// in_ready is low from the cycle after run acceptance until the last result is loaded.
// A stalled out channel holds the walk's emission; rst is synchronous, active high.
`default_nettype none
`include "dfs_spanning_forest_parents_top_assert.svh"

module dfs_spanning_forest_parents_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dfs_pkg::in_req_t  in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output dfs_pkg::out_res_t      out_res,
  input  wire logic              cfg_wr_en,
  input  wire dfs_pkg::vert_t    cfg_wr_data
);

  import dfs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_req.action),
    .status    (status),
    .cmd       (cmd)
  );

  dfs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_res     (out_res)
  );

  // never pop an empty stack
  `DFS_ASSERT_NOW(a_pop_nonempty, cmd.pop, !status.sp_zero)
  // no result is loaded while requests are being taken
  `DFS_ASSERT_NOW(a_emit_not_idle, in_ready, !cmd.emit_load)
  // at most one datapath command per cycle
  `DFS_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0(cmd))
  // a marked vertex is followed by a neighbor scan
  `DFS_ASSERT_NEXT(a_mark_then_scan, cmd.mark, cmd.scan_step)

endmodule

`default_nettype wire
